>>> rtl/matrix_multiply_assert.svh
// Assertion macros for the checker file.
// Both expect clk and rst_n in scope and are held off while reset is low.
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH

// cons must hold in the cycle after ante
`define MM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// cons must hold in the same cycle as ante
`define MM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/mm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mm_pkg;

  // widths fixed by the item fields
  localparam int DIM_W       = 5;   // dimension registers
  localparam int IDX_FIELD_W = 4;   // row/column fields
  localparam int ELEM_W      = 16;  // element field, Q4.12
  localparam int OP_W        = 2;
  localparam int SUM_W       = 36;  // Q12.24 sum, wraps
  localparam int CFG_IDX_W   = 2;

  localparam int IN_TDATA_W  = 24;  // row, col, element
  localparam int OUT_TDATA_W = 48;  // row, col, sum, zero fill

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,     // one A and one B read issued per cycle
    ST_FLUSH,   // last read data into the multiplier
    ST_SETTLE,  // last product into the accumulator
    ST_EMIT     // sum waits for the output register
  } st_t;

endpackage

`default_nettype wire

>>> rtl/matrix_multiply.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                          Carries
// in_       slave      tvalid tready tdata tuser      load A / load B / compute row
// out_      master     tvalid tready tdata tlast      one product element per transfer
// cfg_      write      we index data                  rows_a, inner_dim, cols_b
//
// A compute holds the input until its row is done: for each column, one A word and
// one B word are read per cycle through the single multiply-accumulate path, which
// is then drained through the flush and settle states before the sum is emitted.
// Reset is synchronous; the matrix memories are not cleared.
// A stalled result sits in the output register; loads are taken only while the
// sequencer is idle, and a compute waits before emitting its next sum.

module matrix_multiply
  import mm_pkg::*;
#(
  parameter int MAX_DIM    = 16,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // cfg
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [DIM_W-1:0]       cfg_data,
  // input stream
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // row_index[3:0] col_index[7:4] element[23:8]
  input  wire logic [OP_W-1:0]        in_tuser,   // op[1:0]
  // result stream
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata,  // out_row[3:0] out_col[7:4] product_sum[43:8]
  output      logic                   out_tlast
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int PROD_W  = 2 * DATA_WIDTH;
  localparam int DIM_CAP = (MAX_DIM > 31) ? 31 : MAX_DIM;
  localparam int DIM_RST = (16 > DIM_CAP) ? DIM_CAP : 16;
  localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(MAX_DIM);

  // input fields
  logic [IDX_FIELD_W-1:0]  in_row;
  logic [IDX_FIELD_W-1:0]  in_col;
  logic signed [ELEM_W-1:0] in_element;
  logic                    in_xfer;
  logic                    ld_in_range;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [DATA_WIDTH-1:0] wr_data;
  logic                    wr_a;
  logic                    wr_b;

  assign in_row     = in_tdata[3:0];
  assign in_col     = in_tdata[7:4];
  assign in_element = $signed(in_tdata[23:8]);
  assign in_xfer    = in_tvalid && in_tready;

  assign ld_in_range = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign wr_addr     = ADDR_W'(ADDR_W'(in_row) * STRIDE + ADDR_W'(in_col));
  assign wr_data     = DATA_WIDTH'(in_element);
  assign wr_a        = in_xfer && (in_tuser == OP_LOAD_A) && ld_in_range;
  assign wr_b        = in_xfer && (in_tuser == OP_LOAD_B) && ld_in_range;

  // configuration
  logic [DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic [DIM_W-1:0] cfg_clamped;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = DIM_W'(1);
    end else if (cfg_data > DIM_W'(DIM_CAP)) begin
      cfg_clamped = DIM_W'(DIM_CAP);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(DIM_RST);
      inner_dim_r <= DIM_W'(DIM_RST);
      cols_b_r    <= DIM_W'(DIM_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_A:    rows_a_r    <= cfg_clamped;
        CFG_INNER_DIM: inner_dim_r <= cfg_clamped;
        CFG_COLS_B:    cols_b_r    <= cfg_clamped;
        default:       ;
      endcase
    end
  end

  // sequencer
  st_t                    state_r, state_nxt;
  logic [IDX_W-1:0]       k_r, k_nxt;
  logic [IDX_W-1:0]       j_r, j_nxt;
  logic [IDX_FIELD_W-1:0] row_r, row_nxt;
  logic                   issue;
  logic                   out_load;
  logic                   out_free;
  logic                   k_last, j_last;
  logic                   out_valid_r;

  assign out_free = !out_valid_r || out_tready;
  assign k_last   = (DIM_W'(k_r) == inner_dim_r - DIM_W'(1));
  assign j_last   = (DIM_W'(j_r) == cols_b_r - DIM_W'(1));

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    row_nxt   = row_r;
    issue     = 1'b0;
    out_load  = 1'b0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && (in_tuser == OP_COMPUTE) && (DIM_W'(in_row) < rows_a_r)) begin
          row_nxt   = in_row;
          k_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = ST_FLUSH;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_FLUSH:  state_nxt = ST_SETTLE;
      ST_SETTLE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (j_last) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = ST_RUN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    j_r   <= j_nxt;
    row_r <= row_nxt;
  end

  // matrix memories: one write, one registered read each
  logic signed [DATA_WIDTH-1:0] mem_a [DEPTH];
  logic signed [DATA_WIDTH-1:0] mem_b [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_a_r, rd_b_r;
  logic [ADDR_W-1:0]            rd_addr_a, rd_addr_b;

  assign rd_addr_a = ADDR_W'(ADDR_W'(row_r) * STRIDE + ADDR_W'(k_r));
  assign rd_addr_b = ADDR_W'(ADDR_W'(k_r) * STRIDE + ADDR_W'(j_r));

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_b_r <= mem_b[rd_addr_b];
  end

  // multiply-accumulate pipeline
  logic                     rd_v_r, rd_first_r;
  logic                     prod_v_r, prod_first_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  acc_r, acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= issue;
      prod_v_r <= rd_v_r;
    end
  end

  // sum wraps at SUM_W bits, so a wider product is simply cut
  assign acc_nxt = (prod_first_r ? SUM_W'(0) : acc_r) + SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    rd_first_r   <= (k_r == '0);
    prod_first_r <= rd_first_r;
    prod_r       <= rd_a_r * rd_b_r;
    if (prod_v_r) begin
      acc_r <= acc_nxt;
    end
  end

  // output register
  logic [IDX_FIELD_W-1:0]  out_row_r, out_col_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic                    out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r  <= row_r;
      out_col_r  <= IDX_FIELD_W'(j_r);
      out_sum_r  <= acc_r;
      out_last_r <= j_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_sum_r, out_col_r, out_row_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> rtl/mm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "matrix_multiply_assert.svh"

module mm_checker
  import mm_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [OP_W-1:0]        in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tlast
);

  logic out_stall;
  logic in_load;

  assign out_stall = out_tvalid && !out_tready;
  assign in_load   = in_tvalid && in_tready &&
                     ((in_tuser == OP_LOAD_A) || (in_tuser == OP_LOAD_B));

  `MM_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid, "result dropped while stalled")
  `MM_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  // a load never ties up the sequencer
  `MM_ASSERT_NEXT(a_load_free, in_load, in_tready, "input blocked after a load")
  // mid-row the sequencer is busy, so no new item may be taken
  `MM_ASSERT_NOW(a_row_busy, out_tvalid && !out_tlast, !in_tready, "input open mid-row")

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);

`default_nettype wire
